@@ rtl/bftk_pkg.sv @@
package bftk_pkg;

    localparam int MAX_DIM_DEF = 256;
    localparam int MAX_K_DEF   = 16;

    localparam int QUEUE_DEPTH = 4;

    localparam int VALUE_W = 16;
    localparam int ID_W    = 32;
    localparam int DIST_W  = 40;
    localparam int SCAN_W  = 32;
    localparam int RANK_W  = 4;
    localparam int LEN_W   = 9;
    localparam int KCFG_W  = 5;
    localparam int CMD_W   = 2;
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 3;

    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_COMP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    localparam logic REG_VECTOR_LENGTH     = 1'b0;
    localparam logic REG_NEIGHBOURS_WANTED = 1'b1;

    localparam logic [LEN_W-1:0]  LEN_RESET = 9'd128;
    localparam logic [KCFG_W-1:0] K_RESET   = 5'd16;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [VALUE_W-1:0] value;
        logic [ID_W-1:0]           id;
    } item_t;

    typedef struct packed {
        logic [LEN_W-1:0]  vector_length;
        logic [KCFG_W-1:0] neighbours_wanted;
    } cfg_t;

    typedef struct packed {
        logic clear;
        logic insert;
        logic trunc;
    } list_ctrl_t;

endpackage

@@ rtl/bftk_in_if.sv @@
interface bftk_in_if
    import bftk_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic signed [VALUE_W-1:0] component_value;
    logic [ID_W-1:0]           vector_id;

    modport source (output valid, output command, output component_value, output vector_id,
                    input ready);
    modport sink (input valid, input command, input component_value, input vector_id,
                  output ready);
endinterface

@@ rtl/bftk_out_if.sv @@
interface bftk_out_if
    import bftk_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              found;
    logic [RANK_W-1:0] rank;
    logic [ID_W-1:0]   neighbour_id;
    logic [DIST_W-1:0] distance;
    logic [SCAN_W-1:0] scanned;
    logic              last;

    modport source (output valid, output found, output rank, output neighbour_id,
                    output distance, output scanned, output last, input ready);
    modport sink (input valid, input found, input rank, input neighbour_id,
                  input distance, input scanned, input last, output ready);
endinterface

@@ rtl/bftk_ram.sv @@
module bftk_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/bftk_front.sv @@
module bftk_front
    import bftk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bftk_in_if.sink    in,
    output logic       q_valid,
    output item_t      q_item,
    input  logic       q_pop
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    item_t         queue_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          push;
    logic          pop;

    assign in.ready = (count_reg < NW'(QUEUE_DEPTH));
    // unknown commands are taken and dropped here
    assign push     = in.valid && in.ready && (in.command != CMD_NONE);
    assign pop      = q_pop && q_valid;
    assign q_valid  = (count_reg != '0);
    assign q_item   = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + NW'(push) - NW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= '{command: in.command, value: in.component_value,
                                       id: in.vector_id};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(QUEUE_DEPTH))
        else $error("queue count overflow");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |=> (count_reg <= NW'(1)))
        else $error("queue count moved by more than one from empty");

    a_pop_moves_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (rd_ptr_reg == $past(rd_ptr_reg) + PW'(1)))
        else $error("read pointer did not advance on pop");

endmodule

@@ rtl/bftk_list.sv @@
module bftk_list
    import bftk_pkg::*;
#(
    parameter int MAX_K = MAX_K_DEF,
    localparam int KW = $clog2(MAX_K + 1),
    localparam int RW = (MAX_K > 1) ? $clog2(MAX_K) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  list_ctrl_t        ctrl,
    input  logic [KW-1:0]     k_eff,
    input  logic [DIST_W-1:0] new_dist,
    input  logic [ID_W-1:0]   new_id,
    input  logic [RW-1:0]     rd_index,
    output logic [DIST_W-1:0] rd_dist,
    output logic [ID_W-1:0]   rd_id,
    output logic [KW-1:0]     fill_eff
);

    logic [DIST_W-1:0] cell_dist_reg [MAX_K];
    logic [ID_W-1:0]   cell_id_reg   [MAX_K];
    logic [DIST_W-1:0] prev_dist     [MAX_K];
    logic [ID_W-1:0]   prev_id       [MAX_K];
    logic [KW-1:0]     fill_reg, fill_next;
    logic [MAX_K-1:0]  further;
    logic [MAX_K-1:0]  movable;
    logic [MAX_K-1:0]  slot;
    logic [MAX_K-1:0]  from_prev;
    logic [KW-1:0]     base;
    logic              full;
    logic              drop;
    logic              do_insert;

    assign fill_eff  = (fill_reg > k_eff) ? k_eff : fill_reg;
    assign full      = (fill_eff == k_eff);
    // full list: only a strictly nearer entry pushes out the worst
    assign drop      = full && !(|further);
    assign base      = full ? k_eff - KW'(1) : fill_eff;
    assign do_insert = ctrl.insert && !drop;
    assign rd_dist   = cell_dist_reg[rd_index];
    assign rd_id     = cell_id_reg[rd_index];

    genvar i;
    generate
        for (i = 0; i < MAX_K; i++)
        begin : g_cell
            assign further[i] = (KW'(i) < fill_eff) && (cell_dist_reg[i] > new_dist);
            assign movable[i] = (KW'(i) < base) && further[i];
            assign slot[i]    = movable[i] || (KW'(i) == base);
            if (i == 0)
            begin : g_head
                assign from_prev[i] = 1'b0;
                assign prev_dist[i] = new_dist;
                assign prev_id[i]   = new_id;
            end
            else
            begin : g_body
                assign from_prev[i] = movable[i-1];
                assign prev_dist[i] = cell_dist_reg[i-1];
                assign prev_id[i]   = cell_id_reg[i-1];
            end

            always_ff @(posedge clk)
            begin
                if (do_insert && slot[i])
                begin
                    cell_dist_reg[i] <= from_prev[i] ? prev_dist[i] : new_dist;
                    cell_id_reg[i]   <= from_prev[i] ? prev_id[i] : new_id;
                end
            end

            if (i < MAX_K - 1)
            begin : g_chk
                a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
                    (KW'(i + 1) < fill_reg) |-> (cell_dist_reg[i] <= cell_dist_reg[i+1]))
                    else $error("best list out of order");
            end
        end
    endgenerate

    always_comb
    begin
        fill_next = fill_reg;
        if (ctrl.clear)
        begin
            fill_next = '0;
        end
        else if (ctrl.insert)
        begin
            fill_next = drop ? fill_eff : base + KW'(1);
        end
        else if (ctrl.trunc)
        begin
            fill_next = fill_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= KW'(MAX_K))
        else $error("fill count beyond list size");

    a_insert_fills: assert property (@(posedge clk) disable iff (!rst_n)
        do_insert |=> (fill_reg != '0))
        else $error("insertion left list empty");

endmodule

@@ rtl/bftk_back.sv @@
module bftk_back
    import bftk_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF,
    parameter int MAX_K   = MAX_K_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    bftk_out_if.source  out
);

    localparam int AW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW  = $clog2(MAX_DIM + 1);
    localparam int LW  = (CW > LEN_W) ? CW : LEN_W;
    localparam int KW  = $clog2(MAX_K + 1);
    localparam int RW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int KCW = (KW > KCFG_W) ? KW : KCFG_W;
    localparam int SQ_W = 2 * (VALUE_W + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_INS  = 3'd3;
    localparam logic [2:0] S_REP  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       counter_reg, counter_next;
    logic [DIST_W-1:0]   sum_reg, sum_next;
    logic [SCAN_W-1:0]   scanned_reg, scanned_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [SQ_W-1:0]     sq_reg, sq_next;
    logic [DIST_W-1:0]   ins_dist_reg, ins_dist_next;
    logic [KW-1:0]       n_reg, n_next;
    logic [RW-1:0]       idx_reg, idx_next;

    logic                out_valid_reg, out_valid_next;
    logic                found_reg, found_next;
    logic [RANK_W-1:0]   rank_reg, rank_next;
    logic [ID_W-1:0]     nid_reg, nid_next;
    logic [DIST_W-1:0]   odist_reg, odist_next;
    logic [SCAN_W-1:0]   oscan_reg, oscan_next;
    logic                last_reg, last_next;

    logic [LW-1:0]       len_eff;
    logic [KCW-1:0]      k_wide;
    logic [KW-1:0]       k_eff;
    logic [LW-1:0]       cnt_inc;
    logic                at_end;
    logic [VALUE_W:0]    diff;
    logic [VALUE_W:0]    mag;
    logic [DIST_W:0]     sum_wide;
    logic [DIST_W-1:0]   sum_sat;
    logic                out_free;
    logic                load;
    logic                rep_empty;
    logic                rep_last;

    logic                ram_we;
    logic                ram_re;
    logic [VALUE_W-1:0]  ram_rdata;
    list_ctrl_t          list_ctrl;
    logic [DIST_W-1:0]   rd_dist;
    logic [ID_W-1:0]     rd_id;
    logic [KW-1:0]       fill_eff;

    always_comb
    begin
        if (cfg.vector_length == '0)
        begin
            len_eff = LW'(1);
        end
        else if (LW'(cfg.vector_length) > LW'(MAX_DIM))
        begin
            len_eff = LW'(MAX_DIM);
        end
        else
        begin
            len_eff = LW'(cfg.vector_length);
        end

        if (cfg.neighbours_wanted == '0)
        begin
            k_wide = KCW'(1);
        end
        else if (KCW'(cfg.neighbours_wanted) > KCW'(MAX_K))
        begin
            k_wide = KCW'(MAX_K);
        end
        else
        begin
            k_wide = KCW'(cfg.neighbours_wanted);
        end
    end

    assign k_eff   = KW'(k_wide);
    assign cnt_inc = LW'(counter_reg) + LW'(1);
    assign at_end  = (cnt_inc >= len_eff);

    assign diff     = {ram_rdata[VALUE_W-1], ram_rdata} - {value_reg[VALUE_W-1], value_reg};
    assign mag      = diff[VALUE_W] ? (~diff + (VALUE_W+1)'(1)) : diff;
    assign sum_wide = {1'b0, sum_reg} + (DIST_W+1)'(sq_reg);
    assign sum_sat  = sum_wide[DIST_W] ? '1 : sum_wide[DIST_W-1:0];

    assign out_free  = !out_valid_reg || out.ready;
    assign load      = (state_reg == S_REP) && out_free;
    assign rep_empty = (n_reg == '0);
    assign rep_last  = rep_empty || ((KW'(idx_reg) + KW'(1)) == n_reg);

    assign q_pop  = (state_reg == S_IDLE);
    assign ram_we = (state_reg == S_IDLE) && q_valid && (q_item.command == CMD_QUERY);
    assign ram_re = (state_reg == S_IDLE) && q_valid && (q_item.command == CMD_COMP);

    always_comb
    begin
        state_next    = state_reg;
        counter_next  = counter_reg;
        sum_next      = sum_reg;
        scanned_next  = scanned_reg;
        value_next    = value_reg;
        id_next       = id_reg;
        sq_next       = sq_reg;
        ins_dist_next = ins_dist_reg;
        n_next        = n_reg;
        idx_next      = idx_reg;
        list_ctrl     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_item.command)
                        CMD_QUERY:
                        begin
                            if (counter_reg == '0)
                            begin
                                list_ctrl.clear = 1'b1;
                                scanned_next    = '0;
                            end
                            sum_next     = '0;
                            counter_next = at_end ? '0 : CW'(cnt_inc);
                        end
                        CMD_COMP:
                        begin
                            value_next = q_item.value;
                            id_next    = q_item.id;
                            state_next = S_READ;
                        end
                        CMD_FINISH:
                        begin
                            list_ctrl.trunc = 1'b1;
                            n_next          = fill_eff;
                            idx_next        = '0;
                            counter_next    = '0;
                            sum_next        = '0;
                            state_next      = S_REP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                sq_next    = SQ_W'(mag) * SQ_W'(mag);
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (at_end)
                begin
                    ins_dist_next = sum_sat;
                    sum_next      = '0;
                    counter_next  = '0;
                    scanned_next  = scanned_reg + SCAN_W'(1);
                    state_next    = S_INS;
                end
                else
                begin
                    sum_next     = sum_sat;
                    counter_next = CW'(cnt_inc);
                    state_next   = S_IDLE;
                end
            end
            S_INS:
            begin
                list_ctrl.insert = 1'b1;
                state_next       = S_IDLE;
            end
            S_REP:
            begin
                if (out_free)
                begin
                    if (rep_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + RW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        rank_next      = rank_reg;
        nid_next       = nid_reg;
        odist_next     = odist_reg;
        oscan_next     = oscan_reg;
        last_next      = last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            found_next     = !rep_empty;
            rank_next      = RANK_W'(idx_reg);
            nid_next       = rep_empty ? '0 : rd_id;
            odist_next     = rep_empty ? '0 : rd_dist;
            oscan_next     = scanned_reg;
            last_next      = rep_last;
        end
        else if (out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            counter_reg   <= '0;
            sum_reg       <= '0;
            scanned_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            counter_reg   <= counter_next;
            sum_reg       <= sum_next;
            scanned_reg   <= scanned_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        id_reg       <= id_next;
        sq_reg       <= sq_next;
        ins_dist_reg <= ins_dist_next;
        n_reg        <= n_next;
        idx_reg      <= idx_next;
        found_reg    <= found_next;
        rank_reg     <= rank_next;
        nid_reg      <= nid_next;
        odist_reg    <= odist_next;
        oscan_reg    <= oscan_next;
        last_reg     <= last_next;
    end

    assign out.valid        = out_valid_reg;
    assign out.found        = found_reg;
    assign out.rank         = rank_reg;
    assign out.neighbour_id = nid_reg;
    assign out.distance     = odist_reg;
    assign out.scanned      = oscan_reg;
    assign out.last         = last_reg;

    bftk_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_DIM)
    ) u_query_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (counter_reg[AW-1:0]),
        .wdata (q_item.value),
        .re    (ram_re),
        .raddr (counter_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    bftk_list #(
        .MAX_K (MAX_K)
    ) u_list (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (list_ctrl),
        .k_eff    (k_eff),
        .new_dist (ins_dist_reg),
        .new_id   (id_reg),
        .rd_index (idx_reg),
        .rd_dist  (rd_dist),
        .rd_id    (rd_id),
        .fill_eff (fill_eff)
    );

    a_counter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        counter_reg < CW'(MAX_DIM))
        else $error("component counter past vector store");

    a_last_ends_report: assert property (@(posedge clk) disable iff (!rst_n)
        (load && rep_last) |=> (state_reg == S_IDLE))
        else $error("report continued after final result");

    a_insert_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS) |-> ($past(state_reg) == S_ACC))
        else $error("insertion without completed vector");

    a_read_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> $past(ram_re))
        else $error("square stage without query read");

endmodule

@@ rtl/brute_force_top_k_nearest.sv @@
// channel | dir | payload                                          | transfer
// in      | in  | command, component_value, vector_id              | valid & ready
// out     | out | found, rank, neighbour_id, distance, scanned, last | valid & ready
// apb     | in  | vector_length @0x0, neighbours_wanted @0x4       | psel & penable & pwrite
//
// Query component: written to the query RAM. Stored component: query RAM read, 17x17 square,
// 40-bit accumulate, then, when it closes a vector, list insert in parallel cells.
// Finish: list truncated, then results reported one at a time, k at most, held off by out.ready.
// A 4-entry input queue decouples the two sides; in.ready drops only while it holds 4 items.
// rst_n is asynchronous; query RAM and list cells are not cleared, the fill count is.
module brute_force_top_k_nearest
    import bftk_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF,
    parameter int MAX_K   = MAX_K_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    bftk_in_if.sink            in,
    bftk_out_if.source         out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t  cfg_reg, cfg_next;
    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    assign pready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_VECTOR_LENGTH:     cfg_next.vector_length     = pwdata[LEN_W-1:0];
                REG_NEIGHBOURS_WANTED: cfg_next.neighbours_wanted = pwdata[KCFG_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_VECTOR_LENGTH:     prdata = PDATA_W'(cfg_reg.vector_length);
            REG_NEIGHBOURS_WANTED: prdata = PDATA_W'(cfg_reg.neighbours_wanted);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vector_length     <= LEN_RESET;
            cfg_reg.neighbours_wanted <= K_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bftk_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in      (in),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    bftk_back #(
        .MAX_DIM (MAX_DIM),
        .MAX_K   (MAX_K)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .out     (out)
    );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import bftk_pkg::*;

    typedef struct packed {
        logic              found;
        logic [RANK_W-1:0] rank;
        logic [ID_W-1:0]   neighbour_id;
        logic [DIST_W-1:0] distance;
        logic [SCAN_W-1:0] scanned;
        logic              last;
    } neighbour_t;

    localparam longint unsigned DIST_LIMIT = (64'd1 << DIST_W) - 1;

    class knn_scoreboard;
        logic [VALUE_W-1:0] query_mem [MAX_DIM_DEF];
        bit                 query_set [MAX_DIM_DEF];
        int unsigned        pos;
        longint unsigned    acc;
        longint unsigned    best_dist [MAX_K_DEF];
        logic [ID_W-1:0]    best_id [MAX_K_DEF];
        int unsigned        fill;
        logic [SCAN_W-1:0]  scan_count;
        logic [LEN_W-1:0]   len_reg;
        logic [KCFG_W-1:0]  k_reg;
        neighbour_t         pending [$];
        int unsigned        errors;
        int unsigned        checked;

        function new();
            len_reg    = LEN_RESET;
            k_reg      = K_RESET;
            pos        = 0;
            acc        = 0;
            fill       = 0;
            scan_count = '0;
            errors     = 0;
            checked    = 0;
            foreach (query_set[i])
                query_set[i] = 1'b0;
        endfunction

        function int unsigned eff_len();
            if (len_reg == 0)
                return 1;
            if (len_reg > MAX_DIM_DEF)
                return MAX_DIM_DEF;
            return len_reg;
        endfunction

        function int unsigned eff_k();
            if (k_reg == 0)
                return 1;
            if (k_reg > MAX_K_DEF)
                return MAX_K_DEF;
            return k_reg;
        endfunction

        function void write_reg(logic idx, logic [PDATA_W-1:0] val);
            if (idx == REG_VECTOR_LENGTH)
                len_reg = val[LEN_W-1:0];
            else
                k_reg = val[KCFG_W-1:0];
        endfunction

        // a stored component may only be sent where the query entry holds data
        function bit comp_safe();
            return query_set[pos % MAX_DIM_DEF];
        endfunction

        function void insert_best(longint unsigned d, logic [ID_W-1:0] id);
            int unsigned k;
            int unsigned p;
            k = eff_k();
            if (fill > k)
                fill = k;
            if (fill == k)
            begin
                if (!(d < best_dist[k-1]))
                    return;
                fill = k - 1;
            end
            p = fill;
            while (p > 0 && best_dist[p-1] > d)
            begin
                best_dist[p] = best_dist[p-1];
                best_id[p]   = best_id[p-1];
                p--;
            end
            best_dist[p] = d;
            best_id[p]   = id;
            fill++;
        endfunction

        function void note_item(item_t it);
            int unsigned               idx;
            int unsigned               k;
            logic signed [VALUE_W-1:0] q;
            logic signed [VALUE_W-1:0] v;
            int                        diff;
            longint unsigned           mag;
            neighbour_t                r;
            idx = pos % MAX_DIM_DEF;
            case (it.command)
                CMD_QUERY:
                begin
                    if (pos == 0)
                    begin
                        fill       = 0;
                        scan_count = '0;
                    end
                    query_mem[idx] = it.value;
                    query_set[idx] = 1'b1;
                    acc = 0;
                    pos++;
                    if (pos >= eff_len())
                        pos = 0;
                end
                CMD_COMP:
                begin
                    q    = query_mem[idx];
                    v    = it.value;
                    diff = int'(q) - int'(v);
                    mag  = longint'(diff < 0 ? -diff : diff);
                    acc  = acc + mag * mag;
                    if (acc > DIST_LIMIT)
                        acc = DIST_LIMIT;
                    pos++;
                    if (pos >= eff_len())
                    begin
                        insert_best(acc, it.id);
                        scan_count = scan_count + 1'b1;
                        pos = 0;
                        acc = 0;
                    end
                end
                CMD_FINISH:
                begin
                    k = eff_k();
                    if (fill > k)
                        fill = k;
                    pos = 0;
                    acc = 0;
                    if (fill == 0)
                    begin
                        r = '0;
                        r.scanned = scan_count;
                        r.last    = 1'b1;
                        pending = {pending, r};
                    end
                    else
                    begin
                        for (int unsigned i = 0; i < fill; i++)
                        begin
                            r.found        = 1'b1;
                            r.rank         = RANK_W'(i);
                            r.neighbour_id = best_id[i];
                            r.distance     = best_dist[i][DIST_W-1:0];
                            r.scanned      = scan_count;
                            r.last         = (i + 1 == fill);
                            pending = {pending, r};
                        end
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void compare_field(string field, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            end
        endfunction

        function void check_neighbour(neighbour_t got);
            neighbour_t want;
            checked++;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual id %0h distance %0h",
                         $time, got.neighbour_id, got.distance);
                return;
            end
            want = pending.pop_front();
            compare_field("found", want.found, got.found);
            compare_field("rank", want.rank, got.rank);
            compare_field("neighbour_id", want.neighbour_id, got.neighbour_id);
            compare_field("distance", want.distance, got.distance);
            compare_field("scanned", want.scanned, got.scanned);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    bftk_in_if  in_ch ();
    bftk_out_if out_ch ();

    brute_force_top_k_nearest dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in      (in_ch),
        .out     (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    knn_scoreboard sb = new();

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_req       = 0;
    int unsigned hold_left      = 0;
    int unsigned items_sent     = 0;
    int unsigned reg_writes     = 0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #(5_000_000);
        $display("TEST FAILED");
        $finish;
    end

    // result side: checks each transfer, then picks ready for the next cycle
    initial
    begin
        neighbour_t got;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                got.found        = out_ch.found;
                got.rank         = out_ch.rank;
                got.neighbour_id = out_ch.neighbour_id;
                got.distance     = out_ch.distance;
                got.scanned      = out_ch.scanned;
                got.last         = out_ch.last;
                sb.check_neighbour(got);
            end
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic logic signed [VALUE_W-1:0] pick_value(bit narrow);
        case ($urandom_range(0, 19))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default:
                if (narrow)
                    return VALUE_W'(int'($urandom_range(0, 8)) - 4);
                else
                    return VALUE_W'($urandom);
        endcase
    endfunction

    task automatic send_item(item_t it);
        int unsigned gap;
        gap = 0;
        while (gap < 30 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.command         <= it.command;
        in_ch.component_value <= it.value;
        in_ch.vector_id       <= it.id;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        sb.note_item(it);
        if (it.command != CMD_NONE)
            items_sent++;
    endtask

    task automatic send(logic [CMD_W-1:0] cmd, logic signed [VALUE_W-1:0] val,
                        logic [ID_W-1:0] id);
        item_t it;
        it.command = cmd;
        it.value   = val;
        it.id      = id;
        send_item(it);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [PDATA_W-1:0] val);
        logic [PDATA_W-1:0] mask;
        logic [PDATA_W-1:0] got;
        mask = (idx == REG_VECTOR_LENGTH) ? (1 << LEN_W) - 1 : (1 << KCFG_W) - 1;
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_reg(idx, val);
        sb.compare_field("register readback", val & mask, got);
        reg_writes++;
    endtask

    task automatic directed_checks();
        send(CMD_FINISH, 16'sh0000, 32'h0);
        send(CMD_NONE, 16'sh7FFF, 32'hFFFF_FFFF);

        write_reg(REG_VECTOR_LENGTH, 2);
        write_reg(REG_NEIGHBOURS_WANTED, 2);
        send(CMD_QUERY, 16'sh8000, 32'h0);
        send(CMD_QUERY, 16'sh7FFF, 32'hFFFF_FFFF);
        send(CMD_COMP, 16'sh7FFF, 32'h0000_0001);
        send(CMD_COMP, 16'sh8000, 32'hFFFF_FFFF);
        send(CMD_COMP, 16'sh8000, 32'hA5A5_A5A5);
        send(CMD_COMP, 16'sh7FFF, 32'h5A5A_5A5A);
        send(CMD_COMP, 16'sh8000, 32'h0000_0002);
        send(CMD_COMP, 16'sh7FFF, 32'h0000_0002);
        // equal distance against a full list stays out
        send(CMD_COMP, 16'sh8000, 32'h0000_0003);
        send(CMD_COMP, 16'sh7FFF, 32'h0000_0003);
        send(CMD_FINISH, 16'sh0000, 32'h0);
        send(CMD_COMP, 16'sh0000, 32'h0000_0004);
        send(CMD_FINISH, 16'sh0000, 32'h0);
        write_reg(REG_NEIGHBOURS_WANTED, 1);
        send(CMD_FINISH, 16'sh0000, 32'h0);

        write_reg(REG_NEIGHBOURS_WANTED, 0);
        write_reg(REG_VECTOR_LENGTH, 3);
        send(CMD_QUERY, 16'sh0000, 32'h0);
        send(CMD_QUERY, 16'sh0100, 32'h0);
        send(CMD_QUERY, -16'sh0100, 32'h0);
        send(CMD_COMP, 16'sh0001, 32'h0000_0010);
        send(CMD_COMP, 16'sh0100, 32'h0000_0011);
        // counter already past the shorter length: next component closes the vector
        write_reg(REG_VECTOR_LENGTH, 0);
        send(CMD_COMP, 16'sh0300, 32'h0000_0012);
        send(CMD_FINISH, 16'sh0000, 32'h0);

        write_reg(REG_NEIGHBOURS_WANTED, 31);
        write_reg(REG_VECTOR_LENGTH, 511);
        send(CMD_QUERY, 16'sh1234, 32'h0);
        send(CMD_QUERY, -16'sh1234, 32'h0);
        send(CMD_FINISH, 16'sh0000, 32'h0);
        write_reg(REG_VECTOR_LENGTH, MAX_DIM_DEF);
        send(CMD_QUERY, 16'sh7FFF, 32'h0);
        send(CMD_FINISH, 16'sh0000, 32'h0);
    endtask

    // output held off while finishes keep arriving, so the input queue fills
    task automatic backpressure_burst();
        write_reg(REG_VECTOR_LENGTH, 2);
        write_reg(REG_NEIGHBOURS_WANTED, 16);
        send(CMD_QUERY, pick_value(1'b0), $urandom);
        send(CMD_QUERY, pick_value(1'b0), $urandom);
        for (int v = 0; v < 18; v++)
        begin
            send(CMD_COMP, pick_value(1'b0), $urandom);
            send(CMD_COMP, pick_value(1'b0), $urandom);
        end
        hold_req = 400;
        repeat (8) send(CMD_FINISH, pick_value(1'b0), $urandom);
    endtask

    task automatic run_search();
        int unsigned               r;
        int unsigned               len_val;
        int unsigned               k_val;
        int unsigned               eff;
        int unsigned               nvec;
        int unsigned               noise;
        bit                        narrow;
        bit                        twin;
        logic signed [VALUE_W-1:0] vals [MAX_DIM_DEF];
        logic [ID_W-1:0]           id;
        r = $urandom_range(0, 99);
        if (r < 70)
            len_val = $urandom_range(1, 4);
        else if (r < 88)
            len_val = $urandom_range(5, 12);
        else if (r < 93)
            len_val = 0;
        else if (r < 96)
            len_val = MAX_DIM_DEF;
        else
            len_val = $urandom_range(MAX_DIM_DEF + 1, 511);
        r = $urandom_range(0, 99);
        if (r < 45)
            k_val = $urandom_range(1, 4);
        else if (r < 80)
            k_val = $urandom_range(5, MAX_K_DEF);
        else
            k_val = $urandom_range(0, 31);
        write_reg(REG_VECTOR_LENGTH, len_val);
        write_reg(REG_NEIGHBOURS_WANTED, k_val);
        eff    = sb.eff_len();
        narrow = ($urandom_range(0, 2) == 0);
        if (eff > 12)
        begin
            repeat ($urandom_range(1, 4)) send(CMD_QUERY, pick_value(narrow), $urandom);
            send(CMD_FINISH, pick_value(1'b0), $urandom);
            return;
        end
        for (int c = 0; c < eff; c++)
            send(CMD_QUERY, pick_value(narrow), $urandom);
        nvec = $urandom_range(0, 48 / eff + 2);
        for (int v = 0; v < nvec; v++)
        begin
            twin = (v > 0 && $urandom_range(0, 4) == 0);
            id   = $urandom;
            for (int c = 0; c < eff; c++)
            begin
                noise = $urandom_range(0, 99);
                if (noise < 3)
                    send(CMD_NONE, pick_value(1'b0), $urandom);
                else if (noise == 3)
                    send(CMD_QUERY, pick_value(narrow), $urandom);
                else if (noise == 4)
                    send(CMD_FINISH, pick_value(1'b0), $urandom);
                if (!twin)
                    vals[c] = pick_value(narrow);
                if ($urandom_range(0, 9) == 0)
                    id = $urandom;
                if (sb.comp_safe())
                    send(CMD_COMP, vals[c], id);
                else
                    send(CMD_QUERY, vals[c], id);
            end
        end
        send(CMD_FINISH, pick_value(1'b0), $urandom);
        if ($urandom_range(0, 6) == 0)
            send(CMD_FINISH, pick_value(1'b0), $urandom);
    endtask

    initial
    begin
        int unsigned idle_pct [4];
        int unsigned stall_pct [4];
        int unsigned phase_end;
        idle_pct  = '{0, 85, 0, 13};
        stall_pct = '{0, 0, 85, 13};
        rst_n                 <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        in_ch.valid           <= 1'b0;
        in_ch.command         <= CMD_NONE;
        in_ch.component_value <= '0;
        in_ch.vector_id       <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_checks();
        backpressure_burst();
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = idle_pct[p];
            recv_stall_pct = stall_pct[p];
            phase_end      = items_sent + 75;
            while (items_sent < phase_end)
                run_search();
        end

        recv_stall_pct = 0;
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Run covered %0d input transfers, %0d checked results, %0d register writes,",
                 items_sent, sb.checked, reg_writes);
        $display("under four idle/stall mixes plus one long output hold-off.");
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
